### design/clpr_pkg.sv
// Package for the circular list with positional remove.
// Holds sizes, operation and result codes, controller states, the
// controller/datapath command and status structs, and ring arithmetic.
package clpr_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = $clog2(2 * CAPACITY);
    localparam int OP_W     = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int OCNT_W   = 5;
    localparam int RES_W    = 2;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_BACK  = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [RES_W-1:0] {
        RES_DONE   = 2'd0,
        RES_FULL   = 2'd1,
        RES_BADPOS = 2'd2
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SHIFT,
        ST_DRAIN,
        ST_FRONT_LD,
        ST_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the accepted transaction
        logic do_insert;     // write the value and grow the list
        logic pop_front;     // advance the head, shrink, fetch new front
        logic front_ld;      // take the fetched entry as the front value
        logic dec;           // shrink the list by one entry
        logic shift_init;    // start the gap-closing sweep
        logic shift_step;    // move one entry up by one place
        logic set_res;       // record the result code
        t_res res_code;
        logic out_load;      // load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic full;
        logic bad_pos;
        logic pos_is_one;
        logic needs_shift;
        logic shift_last;
        logic out_free;
    } t_stat;

    // (base + offset) modulo CAPACITY, with base < CAPACITY and
    // offset <= CAPACITY, so one conditional subtract suffices.
    function automatic t_idx ring_add(input t_idx base, input t_cnt offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

endpackage

### design/clpr_if.sv
// Handshake interfaces for the operation channel and the result channel.
// Depends on clpr_pkg for the field widths.
interface clpr_in_if import clpr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0] position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface clpr_out_if import clpr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OCNT_W-1:0] entry_count;
    logic              is_empty;
    logic signed [VAL_W-1:0] front_value;
    logic [RES_W-1:0]  status;

    modport source (output valid, output entry_count, output is_empty,
                    output front_value, output status, input ready);
    modport sink   (input valid, input entry_count, input is_empty,
                    input front_value, input status, output ready);
endinterface

### design/clpr_ctrl.sv
// Controller state machine of the circular list.
// Depends on clpr_pkg; drives commands into clpr_dpath and reads its status.
module clpr_ctrl import clpr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_stat.op == OP_REMOVE && !i_stat.bad_pos) begin
                    if (i_stat.pos_is_one) begin
                        n_state = ST_FRONT_LD;
                    end else if (i_stat.needs_shift) begin
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_SHIFT: begin
                if (i_stat.shift_last) n_state = ST_DRAIN;
            end
            ST_DRAIN:    n_state = ST_RESULT;
            ST_FRONT_LD: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.res_code = RES_DONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.set_res = 1'b1;
                unique case (i_stat.op)
                    OP_INS_FRONT, OP_INS_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.res_code = RES_FULL;
                        end else begin
                            o_cmd.do_insert = 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.bad_pos) begin
                            o_cmd.res_code = RES_BADPOS;
                        end else if (i_stat.pos_is_one) begin
                            o_cmd.pop_front = 1'b1;
                        end else if (i_stat.needs_shift) begin
                            o_cmd.shift_init = 1'b1;
                        end else begin
                            o_cmd.dec = 1'b1;
                        end
                    end
                    OP_NONE: ;
                    default: ;
                endcase
            end
            ST_SHIFT:    o_cmd.shift_step = 1'b1;
            ST_DRAIN:    o_cmd.dec = 1'b1;
            ST_FRONT_LD: o_cmd.front_ld = 1'b1;
            ST_RESULT:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

### design/clpr_dpath.sv
// Datapath of the circular list: entry memory, head and count registers,
// front value register, gap-closing sweep and the output register.
// Depends on clpr_pkg; controlled by clpr_ctrl through t_cmd and t_stat.
module clpr_dpath import clpr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [OP_W-1:0]         i_operation,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0]        i_position,
    input  logic                    i_out_ready,
    output t_stat                   o_stat,
    output logic                    o_out_valid,
    output logic [OCNT_W-1:0]       o_entry_count,
    output logic                    o_is_empty,
    output logic signed [VAL_W-1:0] o_front_value,
    output logic [RES_W-1:0]        o_status
);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rd_data;

    t_op              r_op;
    logic [VAL_W-1:0] r_val;
    logic [POS_W-1:0] r_pos;
    t_idx             r_head;
    t_cnt             r_count;
    logic [VAL_W-1:0] r_front;
    t_cnt             r_idx;
    t_cnt             r_widx;
    logic             r_pend;
    t_res             r_res;

    logic                    r_out_valid;
    logic [OCNT_W-1:0]       r_out_count;
    logic                    r_out_empty;
    logic signed [VAL_W-1:0] r_out_front;
    logic [RES_W-1:0]        r_out_status;

    t_idx             head_dec;
    t_idx             ins_addr;
    t_idx             wr_addr;
    t_idx             rd_addr;
    logic             wr_en;
    logic [VAL_W-1:0] wr_data;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] idx2_ext;

    assign head_dec = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - 1'b1;
    assign ins_addr = (r_op == OP_INS_FRONT) ? head_dec : ring_add(r_head, r_count);

    assign pos_ext  = CMP_W'(r_pos);
    assign cnt_ext  = CMP_W'(r_count);
    assign idx2_ext = CMP_W'(r_idx) + CMP_W'(2);

    assign o_stat.op          = r_op;
    assign o_stat.full        = (cnt_ext >= CMP_W'(CAPACITY));
    assign o_stat.bad_pos     = (r_pos == '0) || (pos_ext > cnt_ext);
    assign o_stat.pos_is_one  = (pos_ext == CMP_W'(1));
    assign o_stat.needs_shift = (pos_ext < cnt_ext);
    assign o_stat.shift_last  = (idx2_ext >= cnt_ext);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // A pending sweep write always lands one place below the entry whose read
    // produced its data, so reads run ahead of writes without a hazard.
    assign wr_en   = r_pend || i_cmd.do_insert;
    assign wr_addr = r_pend ? ring_add(r_head, r_widx) : ins_addr;
    assign wr_data = r_pend ? r_rd_data : r_val;
    assign rd_addr = i_cmd.shift_step ? ring_add(r_head, r_idx + 1'b1)
                                      : ring_add(r_head, t_cnt'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_operation);
            r_val <= i_value;
            r_pos <= i_position;
        end
        if (i_cmd.set_res) begin
            r_res <= i_cmd.res_code;
        end
        if (i_cmd.front_ld) begin
            r_front <= r_rd_data;
        end else if (i_cmd.do_insert &&
                     (r_op == OP_INS_FRONT || r_count == '0)) begin
            r_front <= r_val;
        end
        if (i_cmd.shift_init) begin
            r_idx <= t_cnt'(r_pos - 1'b1);
        end else if (i_cmd.shift_step) begin
            r_idx  <= r_idx + 1'b1;
            r_widx <= r_idx;
        end
        if (i_cmd.out_load) begin
            r_out_count  <= OCNT_W'(r_count);
            r_out_empty  <= (r_count == '0);
            r_out_front  <= (r_count == '0) ? '0 : r_front;
            r_out_status <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.shift_step;
            if (i_cmd.do_insert) begin
                r_count <= r_count + 1'b1;
                if (r_op == OP_INS_FRONT) begin
                    r_head <= head_dec;
                end
            end else if (i_cmd.pop_front) begin
                r_count <= r_count - 1'b1;
                r_head  <= ring_add(r_head, t_cnt'(1));
            end else if (i_cmd.dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_front_value = r_out_front;
    assign o_status      = r_out_status;

endmodule

### design/circular_list_with_positional_remove_core.sv
// Top level of the circular list with positional remove.
// Depends on clpr_pkg, clpr_if, clpr_ctrl and clpr_dpath.
//
// Usage:
//   i_in carries one operation per transaction: insert at front, insert at
//   back, or remove at a 1-based position. o_out returns exactly one result
//   transaction per operation: the entry count after the operation, an empty
//   flag, the front value (zero when empty) and a status code (done, full
//   and insert dropped, or bad position ignored).
//   The block works on one operation at a time. i_in.ready is high only
//   while the controller is idle; an accepted operation is decoded in the
//   next cycle. Inserts, rejected operations and removes of the last entry
//   behind the front go from the decode state straight to the result
//   state, which loads the output register. A remove at the first position
//   passes through a state that fetches the new front from the entry memory.
//   A remove at a later position closes the gap by moving each entry behind
//   it up one place, one entry per cycle through the entry memory's one read
//   and one write port, then a drain state finishes the last write.
//   A finished result waits in the output register; if the receiver stalls,
//   the controller holds the next result in the datapath and keeps i_in.ready
//   low until the register frees up.
//   Synchronous reset empties the list and drops any pending result; the
//   entry memory itself is not cleared and needs no clearing pass.
module circular_list_with_positional_remove_core import clpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clpr_in_if.sink           i_in,
    clpr_out_if.source        o_out
);

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences each transaction; it never touches payload.
    clpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // The datapath owns the list storage and the output register.
    clpr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_in.operation),
        .i_value       (i_in.value),
        .i_position    (i_in.position),
        .i_out_ready   (o_out.ready),
        .o_stat        (stat),
        .o_out_valid   (o_out.valid),
        .o_entry_count (o_out.entry_count),
        .o_is_empty    (o_out.is_empty),
        .o_front_value (o_out.front_value),
        .o_status      (o_out.status)
    );

    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (int'(o_out.entry_count) <= CAPACITY))
        else $error("entry count exceeds capacity");

    // An empty list reports a zero count and a zero front value.
    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |->
            (o_out.entry_count == '0 && o_out.front_value == '0))
        else $error("empty result with nonzero count or front");

    // A dropped insert is only reported when the list is at capacity.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == RES_FULL) |->
            (int'(o_out.entry_count) == CAPACITY))
        else $error("full status below capacity");

    // After acceptance the controller is busy and takes no new transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("transaction accepted while busy");

endmodule
